[design/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent must hold in the same cycle
`define DPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds, consequent must hold in the following cycle
`define DPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/dpm_pkg.sv]
// constants, tables and types of the point to mercator projector
package dpm_pkg;

  localparam int COORD_BITS    = 32;
  localparam int OUT_FRAC_BITS = 12;
  localparam int CORDIC_STEPS  = 24;
  localparam int GUARD_BITS    = 16;
  localparam int ANG_FRAC      = 40;
  localparam int SER_FRAC      = 60;
  localparam int TAB_LEN       = 41;
  localparam int N_STEPS       = (CORDIC_STEPS < TAB_LEN - 1) ? CORDIC_STEPS : TAB_LEN - 1;
  localparam int STEP_W        = $clog2(TAB_LEN);
  localparam int SUM_W         = ((COORD_BITS > 32) ? COORD_BITS : 32) + 1;
  localparam int PROD_SHIFT    = GUARD_BITS + ANG_FRAC - OUT_FRAC_BITS;
  localparam int OUT_W         = 48;
  localparam int K_W           = 6;
  localparam int K_MAX         = 62;
  localparam int SH_W          = 7;
  localparam logic [63:0] OUT_MAX = 64'h0000_7FFF_FFFF_FFFF;

  // hyperbolic steps that run twice, where the step count reaches them
  localparam int HREP_A = 4;
  localparam int HREP_B = 13;
  localparam int HREP_C = 40;

  typedef logic [63:0] tab_t [TAB_LEN];

  typedef struct packed {
    logic             start;
    logic [63:0]      a;
    logic [63:0]      b;
    logic [SH_W-1:0]  shift;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } mul_rsp_t;

  // restoring division for the elaboration-time series
  function automatic logic [63:0] cdiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int j = 63; j >= 0; j--) begin
      rem = {rem[63:0], num[j]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) or atanh(1/n) scaled by 2^SER_FRAC, elaboration only
  function automatic logic [63:0] series(input logic [63:0] n, input bit alt);
    logic [63:0] p;
    logic [63:0] acc;
    logic [63:0] t;
    logic [63:0] k;
    bit          neg;
    p   = cdiv(64'd1 << SER_FRAC, n);
    acc = '0;
    k   = 64'd1;
    neg = 1'b0;
    for (int j = 0; j < 64; j++) begin
      if (p != 0) begin
        t = cdiv(p, k);
        if (alt && neg) acc = acc - t;
        else acc = acc + t;
        neg = !neg;
        p   = cdiv(cdiv(p, n), n);
        k   = k + 64'd2;
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] to_q(input logic [63:0] v);
    return (v + (64'd1 << (SER_FRAC - ANG_FRAC - 1))) >> (SER_FRAC - ANG_FRAC);
  endfunction

  function automatic logic [63:0] mulsh_c(input logic [63:0] a, input logic [63:0] b,
                                          input int s);
    logic [127:0] pr;
    pr = {64'd0, a} * {64'd0, b};
    pr = pr >> s;
    return (pr[127:64] != 0) ? '1 : pr[63:0];
  endfunction

  function automatic tab_t gen_atan();
    tab_t t;
    for (int i = 0; i < TAB_LEN; i++) begin
      if (i == 0) t[i] = to_q(series(64'd2, 1'b1) + series(64'd3, 1'b1));
      else t[i] = to_q(series(64'd1 << i, 1'b1));
    end
    return t;
  endfunction

  function automatic tab_t gen_atanh();
    tab_t t;
    for (int i = 0; i < TAB_LEN; i++) begin
      if (i == 0) t[i] = '0;
      else t[i] = to_q(series(64'd1 << i, 1'b0));
    end
    return t;
  endfunction

  // reciprocal cordic gain, 62 fraction bits
  function automatic logic [63:0] gen_inv_gain();
    logic [63:0] k2;
    logic [63:0] y;
    logic [63:0] t;
    k2 = 64'd1 << 62;
    for (int i = 1; i < N_STEPS; i++) begin
      if (2 * i < 64) k2 = k2 + (k2 >> (2 * i));
    end
    y = 64'd5 << 59;
    for (int i = 0; i < 8; i++) begin
      t = mulsh_c(k2, mulsh_c(y, y, 62), 61);
      y = mulsh_c(y, (64'd3 << 62) - t, 63);
    end
    return y;
  endfunction

  localparam logic [63:0] QUART_SER = series(64'd2, 1'b1) + series(64'd3, 1'b1);
  localparam logic [63:0] PI_Q      = to_q(QUART_SER * 4);
  localparam logic [63:0] HALF_PI_Q = to_q(QUART_SER * 2);
  localparam logic [63:0] LN2_Q     = to_q(2 * series(64'd3, 1'b0));
  localparam logic [63:0] INV_GAIN  = gen_inv_gain();
  localparam tab_t        ATAN_TAB  = gen_atan();
  localparam tab_t        ATANH_TAB = gen_atanh();

endpackage

[design/dpm_if.sv]
// valid/ready channels of the point to mercator projector
interface dpm_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic signed [31:0] z_value;

  modport source (output valid, func, x_value, y_value, z_value, input ready);
  modport sink   (input valid, func, x_value, y_value, z_value, output ready);
endinterface

interface dpm_out_if;
  logic        valid;
  logic        ready;
  logic signed [47:0] easting;
  logic signed [47:0] northing;
  logic        at_pole;
  logic        clipped;

  modport source (output valid, easting, northing, at_pole, clipped, input ready);
  modport sink   (input valid, easting, northing, at_pole, clipped, output ready);
endinterface

[design/dpm_mul.sv]
// serial 64x64 multiplier, 16 bits of b per cycle, shifted and saturated result
module dpm_mul import dpm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  localparam int CHUNK_W = 16;
  localparam int CHUNKS  = 64 / CHUNK_W;
  localparam int CNT_W   = $clog2(CHUNKS);

  logic [63:0]      a_q;
  logic [63:0]      b_q;
  logic [SH_W-1:0]  sh_q;
  logic [127:0]     acc_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             fin_q;
  logic             done_q;
  logic [63:0]      res_q;

  logic [63+CHUNK_W:0] part;
  logic [127:0]        shifted;

  assign part    = a_q * b_q[CHUNK_W-1:0];
  assign shifted = acc_q >> sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        a_q    <= req_i.a;
        b_q    <= req_i.b;
        sh_q   <= req_i.shift;
        acc_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q <= acc_q + (128'(part) << (CHUNK_W * cnt_q));
        b_q   <= b_q >> CHUNK_W;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CHUNKS - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        res_q  <= (shifted[127:64] != 0) ? '1 : shifted[63:0];
        done_q <= 1'b1;
        fin_q  <= 1'b0;
      end
    end
  end

  assign rsp_o = '{done: done_q, result: res_q};

endmodule

[design/delta_point_to_mercator.sv]
// Point stream to spherical Mercator projector.
// in_i carries one point beat: func 0 loads x, y, z as the new point, func 1
// adds them to the stored point; each coordinate saturates and sets clipped.
// out_o carries one result beat per input beat: easting -r*theta and northing
// r*ln(cot(fi/2)) with 12 fraction bits, at_pole for points on the z axis.
// in_i.ready is high only while the sequencer is idle; one point is in work
// at a time. One cordic step unit runs 24 circular steps for the longitude,
// 24 for the radius and 26 hyperbolic steps for the log, a normalize loop
// doubles the horizontal distance k times (0 to 62, once a cycle), and four
// products go through a serial multiplier. out_o.valid rises when the result
// is loaded into the output register, and in_i.ready returns in that same
// cycle. A zero or saturated log skips the normalize loop and the hyperbolic
// pass, and a point on the pole skips all cordic and multiplier work.
// The result sits in an output register; the next point is accepted while it
// waits, and the sequencer holds the following result until out_o is ready.
// Reset clears the stored point to the origin and drops out_o.valid.
module delta_point_to_mercator import dpm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  dpm_in_if.sink    in_i,
  dpm_out_if.source out_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_CV1, S_MRHO, S_CV2, S_MR, S_ME, S_NORM, S_HV, S_MN, S_DONE
  } state_e;

  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  state_e state_q;

  logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
  logic              clip_q;
  logic              pole_q;
  logic signed [63:0] cx_q, cy_q, acc_q;
  logic [STEP_W-1:0] step_q;
  logic              rep_q;
  logic [63:0]       theta_q, rho_q, r_q, zabs_q, a_q, bsh_q;
  logic [63:0]       e_mag_q, n_mag_q;
  logic [K_W-1:0]    k_q;
  mul_req_t          mreq_q;
  mul_req_t          mreq_d;
  mul_rsp_t          mrsp;

  logic              ov_q, op_q, oc_q;
  logic              ov_d, out_load;
  logic [OUT_W-1:0]  oe_q, on_q;

  // saturating point update
  function automatic logic [COORD_BITS:0] clamp_c(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(C_MAX)) return {1'b1, C_MAX};
    if (v < SUM_W'(C_MIN)) return {1'b1, C_MIN};
    return {1'b0, v[COORD_BITS-1:0]};
  endfunction

  logic signed [SUM_W-1:0] sx, sy, sz;
  logic [COORD_BITS:0]     cl_x, cl_y, cl_z;

  always_comb begin
    sx = in_i.func ? SUM_W'(px_q) + SUM_W'(in_i.x_value) : SUM_W'(in_i.x_value);
    sy = in_i.func ? SUM_W'(py_q) + SUM_W'(in_i.y_value) : SUM_W'(in_i.y_value);
    sz = in_i.func ? SUM_W'(pz_q) + SUM_W'(in_i.z_value) : SUM_W'(in_i.z_value);
    cl_x = clamp_c(sx);
    cl_y = clamp_c(sy);
    cl_z = clamp_c(sz);
  end

  // scaled coordinates for the first vectoring pass
  logic signed [63:0] xs, yabs, zabs;
  always_comb begin
    xs   = 64'(px_q) <<< GUARD_BITS;
    yabs = (py_q < 0) ? -64'(py_q) : 64'(py_q);
    yabs = yabs <<< GUARD_BITS;
    zabs = (pz_q < 0) ? -64'(pz_q) : 64'(pz_q);
    zabs = zabs <<< GUARD_BITS;
  end

  // shared cordic step unit, circular or hyperbolic
  logic               hyp;
  logic signed [63:0] sdx, sdy, nx, ny, nacc;
  logic [63:0]        tabv;
  always_comb begin
    hyp  = (state_q == S_HV);
    sdx  = cy_q >>> step_q;
    sdy  = cx_q >>> step_q;
    tabv = hyp ? ATANH_TAB[step_q] : ATAN_TAB[step_q];
    if (!cy_q[63]) begin
      nx   = hyp ? cx_q - sdx : cx_q + sdx;
      ny   = cy_q - sdy;
      nacc = acc_q + $signed(tabv);
    end else begin
      nx   = hyp ? cx_q + sdx : cx_q - sdx;
      ny   = cy_q + sdy;
      nacc = acc_q - $signed(tabv);
    end
  end

  // longitude from the clamped angle
  logic [63:0] ang, theta;
  always_comb begin
    if (acc_q < 0) ang = '0;
    else if (acc_q > $signed(PI_Q)) ang = PI_Q;
    else ang = acc_q;
    if (py_q < 0) theta = (PI_Q << 1) - ((ang == 0) ? 64'd1 : ang);
    else theta = ang;
  end

  logic hrep;
  assign hrep = (step_q == STEP_W'(HREP_A)) || (step_q == STEP_W'(HREP_B)) ||
                (step_q == STEP_W'(HREP_C));

  logic [63:0]        kl, bsh2;
  logic signed [63:0] lnv_raw;
  logic [63:0]        lnv;
  logic [63:0]        a_sum;
  always_comb begin
    kl      = 64'(k_q * LN2_Q);
    lnv_raw = $signed(kl) + (acc_q <<< 1);
    lnv     = lnv_raw[63] ? '0 : lnv_raw;
    bsh2    = bsh_q << 1;
    a_sum   = r_q + zabs_q;
  end

  // multiplier request, a one-cycle start pulse
  always_comb begin
    mreq_d = '{start: 1'b0, a: cx_q, b: INV_GAIN, shift: SH_W'(62)};
    case (state_q)
      S_CV1, S_CV2: mreq_d.start = (step_q == STEP_W'(N_STEPS));
      S_MR: begin
        mreq_d = '{start: mrsp.done, a: mrsp.result, b: theta_q,
                   shift: SH_W'(PROD_SHIFT)};
      end
      S_HV: begin
        mreq_d = '{start: (step_q == STEP_W'(N_STEPS + 1)), a: r_q, b: lnv,
                   shift: SH_W'(PROD_SHIFT)};
      end
      default: ;
    endcase
  end

  assign out_load = (state_q == S_DONE) && (!ov_q || out_o.ready);
  assign ov_d     = out_load || (ov_q && !out_o.ready);

  logic [63:0] e_sat, n_sat, e_neg, n_neg;
  always_comb begin
    e_sat = (e_mag_q > OUT_MAX) ? OUT_MAX : e_mag_q;
    n_sat = (n_mag_q > OUT_MAX) ? OUT_MAX : n_mag_q;
    e_neg = 64'd0 - e_sat;
    n_neg = pz_q[COORD_BITS-1] ? 64'd0 - n_sat : n_sat;
  end

  dpm_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq_q),
    .rsp_o  (mrsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      px_q         <= '0;
      py_q         <= '0;
      pz_q         <= '0;
      mreq_q       <= '0;
      ov_q         <= 1'b0;
    end else begin
      mreq_q <= mreq_d;
      ov_q   <= ov_d;
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            px_q    <= cl_x[COORD_BITS-1:0];
            py_q    <= cl_y[COORD_BITS-1:0];
            pz_q    <= cl_z[COORD_BITS-1:0];
            clip_q  <= cl_x[COORD_BITS] | cl_y[COORD_BITS] | cl_z[COORD_BITS];
            state_q <= S_SETUP;
          end
        end
        S_SETUP: begin
          pole_q <= (px_q == 0) && (py_q == 0);
          zabs_q <= zabs;
          step_q <= '0;
          if (xs < 0) begin
            cx_q  <= yabs;
            cy_q  <= -xs;
            acc_q <= $signed(HALF_PI_Q);
          end else begin
            cx_q  <= xs;
            cy_q  <= yabs;
            acc_q <= '0;
          end
          if ((px_q == 0) && (py_q == 0)) begin
            e_mag_q <= '0;
            n_mag_q <= OUT_MAX;
            state_q <= S_DONE;
          end else begin
            state_q <= S_CV1;
          end
        end
        S_CV1: begin
          if (step_q == STEP_W'(N_STEPS)) begin
            theta_q      <= theta;
            state_q      <= S_MRHO;
          end else begin
            cx_q   <= nx;
            cy_q   <= ny;
            acc_q  <= nacc;
            step_q <= step_q + 1'b1;
          end
        end
        S_MRHO: begin
          if (mrsp.done) begin
            rho_q   <= mrsp.result;
            cx_q    <= mrsp.result;
            cy_q    <= zabs_q;
            acc_q   <= '0;
            step_q  <= '0;
            state_q <= S_CV2;
          end
        end
        S_CV2: begin
          if (step_q == STEP_W'(N_STEPS)) begin
            state_q <= S_MR;
          end else begin
            cx_q   <= nx;
            cy_q   <= ny;
            acc_q  <= nacc;
            step_q <= step_q + 1'b1;
          end
        end
        S_MR: begin
          if (mrsp.done) begin
            r_q     <= mrsp.result;
            state_q <= S_ME;
          end
        end
        S_ME: begin
          if (mrsp.done) begin
            e_mag_q <= mrsp.result;
            a_q     <= a_sum;
            bsh_q   <= rho_q;
            k_q     <= '0;
            if (rho_q == 0) begin
              n_mag_q <= OUT_MAX;
              state_q <= S_DONE;
            end else if (a_sum <= rho_q) begin
              n_mag_q <= '0;
              state_q <= S_DONE;
            end else begin
              state_q <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if ((k_q < K_W'(K_MAX)) && (bsh2 <= a_q)) begin
            bsh_q <= bsh2;
            k_q   <= k_q + 1'b1;
          end else begin
            cx_q    <= a_q + bsh_q;
            cy_q    <= a_q - bsh_q;
            acc_q   <= '0;
            step_q  <= STEP_W'(1);
            rep_q   <= 1'b0;
            state_q <= S_HV;
          end
        end
        S_HV: begin
          if (step_q == STEP_W'(N_STEPS + 1)) begin
            state_q <= S_MN;
          end else begin
            cx_q  <= nx;
            cy_q  <= ny;
            acc_q <= nacc;
            // some steps run twice for convergence
            if (hrep && !rep_q) begin
              rep_q <= 1'b1;
            end else begin
              rep_q  <= 1'b0;
              step_q <= step_q + 1'b1;
            end
          end
        end
        S_MN: begin
          if (mrsp.done) begin
            n_mag_q <= mrsp.result;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            oe_q    <= e_neg[OUT_W-1:0];
            on_q    <= n_neg[OUT_W-1:0];
            op_q    <= pole_q;
            oc_q    <= clip_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = ov_q;
  assign out_o.easting  = oe_q;
  assign out_o.northing = on_q;
  assign out_o.at_pole  = op_q;
  assign out_o.clipped  = oc_q;

endmodule

[design/dpm_checker.sv]
// port checks of the point to mercator projector and their bind
`include "assert_macros.svh"

module dpm_checker import dpm_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [OUT_W-1:0] easting_i,
  input logic [OUT_W-1:0] northing_i,
  input logic             at_pole_i
);

  localparam logic [OUT_W-1:0] N_POS = OUT_MAX[OUT_W-1:0];
  localparam logic [OUT_W-1:0] N_NEG = OUT_W'(0) - OUT_MAX[OUT_W-1:0];

  `DPM_ASSERT_IMP(a_pole_east, out_valid_i && at_pole_i, easting_i == '0, "pole with easting")
  `DPM_ASSERT_IMP(a_pole_north, out_valid_i && at_pole_i, (northing_i == N_POS) || (northing_i == N_NEG), "pole northing not saturated")
  `DPM_ASSERT_IMP(a_east_sign, out_valid_i, easting_i[OUT_W-1] || (easting_i == '0), "positive easting")
  `DPM_ASSERT_NEXT(a_busy, in_valid_i && in_ready_i, !in_ready_i, "ready right after accept")
  `DPM_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result beat dropped")

endmodule

bind delta_point_to_mercator dpm_checker u_dpm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .easting_i   (out_o.easting),
  .northing_i  (out_o.northing),
  .at_pole_i   (out_o.at_pole)
);
